>>> rtl/bf2h_pkg.sv
// Shared constants and hash step functions for the two-hash Bloom filter.
package bf2h_pkg;

    localparam int DEF_MAX_SLOTS = 65536;

    localparam int HASH_W = 32;
    localparam int BYTE_W = 8;
    localparam int SIZE_W = 17;
    localparam int DATA_W = 32;
    localparam int ADDR_W_APB = 3;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RESET = 17'd65536;

    // Register index decoded from paddr[2].
    localparam logic REG_TABLE_SIZE = 1'b0;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    localparam int MUL_SHIFT  = 5;
    localparam int ELF_SHIFT  = 4;
    localparam int FOLD_SHIFT = 24;
    localparam logic [HASH_W-1:0] TOP_NIBBLE = 32'hF000_0000;

    function automatic logic [HASH_W-1:0] sext_byte(input logic [BYTE_W-1:0] b);
        return {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    endfunction

    // h * 31 + c by shift and subtract; a zero byte c leaves h unchanged.
    function automatic logic [HASH_W-1:0] mul_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] r;
        r = h;
        if (b != '0)
        begin
            r = (h << MUL_SHIFT) - h + sext_byte(b);
        end
        return r;
    endfunction

    function automatic logic [HASH_W-1:0] elf_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] t;
        logic [HASH_W-1:0] g;
        t = h;
        if (b != '0)
        begin
            t = (h << ELF_SHIFT) + sext_byte(b);
            g = t & TOP_NIBBLE;
            t = (t ^ (g >> FOLD_SHIFT)) & ~g;
        end
        return t;
    endfunction

endpackage

>>> rtl/bf2h_if.sv
// Valid/ready channel interfaces for key bytes and results.
interface bf2h_key_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] key_byte;
    logic       last;

    modport source (output valid, output opcode, output key_byte, output last, input ready);
    modport sink   (input valid, input opcode, input key_byte, input last, output ready);
endinterface

interface bf2h_res_if;
    logic valid;
    logic ready;
    logic was_query;
    logic found;

    modport source (output valid, output was_query, output found, input ready);
    modport sink   (input valid, input was_query, input found, output ready);
endinterface

>>> rtl/bf2h_mod.sv
// Shared restoring remainder unit: one quotient bit per cycle over a 32-bit dividend.
module bf2h_mod
    import bf2h_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] dividend,
    input  logic [SIZE_W-1:0] divisor,
    output logic              done,
    output logic [SIZE_W-1:0] remainder
);

    localparam int CNT_W = $clog2(HASH_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [HASH_W-1:0] dvd_reg, dvd_next;
    logic [SIZE_W-1:0] dvs_reg, dvs_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic [SIZE_W:0]   trial;

    // The partial remainder stays below the divisor, so one shifted bit fits in SIZE_W+1.
    assign trial = {rem_reg, dvd_reg[HASH_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dvs_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = SIZE_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[SIZE_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(HASH_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

>>> rtl/bf2h_bitmem.sv
// Filter bit memory with a clearing pass after reset and a registered read port.
module bf2h_bitmem
    import bf2h_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int ADDR_W    = $clog2(MAX_SLOTS)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              set_en,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] addr,
    output logic              rd_data,
    output logic              clr_busy
);

    logic              mem [MAX_SLOTS];
    logic              clr_busy_reg, clr_busy_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_data;

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(MAX_SLOTS - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign wr_en   = clr_busy_reg | set_en;
    assign wr_addr = clr_busy_reg ? clr_addr_reg : addr;
    assign wr_data = !clr_busy_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

>>> rtl/bloom_filter_two_hash.sv
// Top level of the two-hash Bloom filter: hashing, sequencer and APB register.
//
//  channel    dir   handshake            word
//  key_ch     in    valid/ready          opcode, key_byte, last
//  result_ch  out   valid/ready          was_query, found
//  APB        in    psel/penable/pready  table_size at byte address 0
//
// A byte that is not last is absorbed in S_IDLE, which stays ready. A last byte
// takes two 32-step remainders on the shared unit, then states S_MEM1, S_MEM2 and S_MEM3.
// After reset the bit memory is cleared one slot a cycle over all MAX_SLOTS slots, and no
// key word is taken meanwhile. A finished result waits in the output register;
// the next key may be taken, but after its bit memory cycles it holds (not ready)
// until that register is free.
module bloom_filter_two_hash
    import bf2h_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    bf2h_key_if.sink              key_ch,
    bf2h_res_if.source            result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W_APB-1:0] paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    localparam int ADDR_W = $clog2(MAX_SLOTS);

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_DIV1_GO   = 9'b000000010,
        S_DIV1_WAIT = 9'b000000100,
        S_DIV2_GO   = 9'b000001000,
        S_DIV2_WAIT = 9'b000010000,
        S_MEM1      = 9'b000100000,
        S_MEM2      = 9'b001000000,
        S_MEM3      = 9'b010000000,
        S_SPARE     = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] table_size_reg, table_size_next;
    logic [HASH_W-1:0] mul_hash_reg, mul_hash_next;
    logic [HASH_W-1:0] elf_hash_reg, elf_hash_next;
    logic              op_reg, op_next;
    logic [SIZE_W-1:0] slot1_reg, slot1_next;
    logic [SIZE_W-1:0] slot2_reg, slot2_next;
    logic              bit1_reg, bit1_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_query_reg, out_query_next;
    logic              out_found_reg, out_found_next;

    logic              cfg_wr;
    logic [SIZE_W-1:0] eff_size;
    logic              key_acc;
    logic              div_start;
    logic [HASH_W-1:0] div_dividend;
    logic              div_done;
    logic [SIZE_W-1:0] div_rem;
    logic              mem_set;
    logic              mem_rd;
    logic [SIZE_W-1:0] mem_slot;
    logic              mem_rd_data;
    logic              clr_busy;
    logic              out_free;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE);

    always_comb
    begin
        table_size_next = table_size_reg;
        if (cfg_wr)
        begin
            table_size_next = pwdata[SIZE_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_TABLE_SIZE)
        begin
            prdata = DATA_W'(table_size_reg);
        end
    end

    // A size of zero behaves as one, and sizes past the memory saturate.
    always_comb
    begin
        if (table_size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(table_size_reg) > 32'(MAX_SLOTS))
        begin
            eff_size = SIZE_W'(MAX_SLOTS);
        end
        else
        begin
            eff_size = table_size_reg;
        end
    end

    assign key_ch.ready = (state_reg == S_IDLE) && !clr_busy;
    assign key_acc      = key_ch.valid && key_ch.ready;

    assign div_start    = (state_reg == S_DIV1_GO) || (state_reg == S_DIV2_GO);
    assign div_dividend = (state_reg == S_DIV2_GO) ? elf_hash_reg : mul_hash_reg;

    assign out_free = !out_valid_reg || result_ch.ready;

    always_comb
    begin
        state_next     = state_reg;
        mul_hash_next  = mul_hash_reg;
        elf_hash_next  = elf_hash_reg;
        op_next        = op_reg;
        slot1_next     = slot1_reg;
        slot2_next     = slot2_reg;
        bit1_next      = bit1_reg;
        out_query_next = out_query_reg;
        out_found_next = out_found_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        mem_set        = 1'b0;
        mem_rd         = 1'b0;
        mem_slot       = slot1_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (key_acc)
                begin
                    mul_hash_next = mul_step(mul_hash_reg, key_ch.key_byte);
                    elf_hash_next = elf_step(elf_hash_reg, key_ch.key_byte);
                    if (key_ch.last)
                    begin
                        op_next    = key_ch.opcode;
                        state_next = S_DIV1_GO;
                    end
                end
            end
            S_DIV1_GO:
            begin
                state_next = S_DIV1_WAIT;
            end
            S_DIV1_WAIT:
            begin
                if (div_done)
                begin
                    slot1_next = div_rem;
                    state_next = S_DIV2_GO;
                end
            end
            S_DIV2_GO:
            begin
                // The divider has taken both hashes now; start the next key from zero.
                mul_hash_next = '0;
                elf_hash_next = '0;
                state_next    = S_DIV2_WAIT;
            end
            S_DIV2_WAIT:
            begin
                if (div_done)
                begin
                    slot2_next = div_rem;
                    state_next = S_MEM1;
                end
            end
            S_MEM1:
            begin
                mem_slot   = slot1_reg;
                mem_set    = (op_reg == OP_INSERT);
                mem_rd     = (op_reg == OP_QUERY);
                state_next = S_MEM2;
            end
            S_MEM2:
            begin
                mem_slot   = slot2_reg;
                mem_set    = (op_reg == OP_INSERT);
                mem_rd     = (op_reg == OP_QUERY);
                bit1_next  = mem_rd_data;
                state_next = S_MEM3;
            end
            S_MEM3:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_query_next = op_reg;
                    out_found_next = (op_reg == OP_QUERY) && bit1_reg && mem_rd_data;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            table_size_reg <= TABLE_SIZE_RESET;
            mul_hash_reg   <= '0;
            elf_hash_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            table_size_reg <= table_size_next;
            mul_hash_reg   <= mul_hash_next;
            elf_hash_reg   <= elf_hash_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        slot1_reg     <= slot1_next;
        slot2_reg     <= slot2_next;
        bit1_reg      <= bit1_next;
        out_query_reg <= out_query_next;
        out_found_reg <= out_found_next;
    end

    bf2h_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (eff_size),
        .done      (div_done),
        .remainder (div_rem)
    );

    bf2h_bitmem #(
        .MAX_SLOTS (MAX_SLOTS),
        .ADDR_W    (ADDR_W)
    ) u_bitmem (
        .clk      (clk),
        .rst_n    (rst_n),
        .set_en   (mem_set),
        .rd_en    (mem_rd),
        .addr     (ADDR_W'(mem_slot)),
        .rd_data  (mem_rd_data),
        .clr_busy (clr_busy)
    );

    assign result_ch.valid     = out_valid_reg;
    assign result_ch.was_query = out_query_reg;
    assign result_ch.found     = out_found_reg;

endmodule
